>>> rtl/ills_pkg.sv
// ----------------------------------------------------------------------------
// Indexed linked list store package
// Shared field widths, request and status codes, controller states and the
// control group that drives the slot memories.
// ----------------------------------------------------------------------------
package ills_pkg;

   // Default number of slots in the store
   localparam int DEFAULT_CAPACITY = 64;

   // Field widths of the stream items
   localparam int KIND_W      = 3;
   localparam int POS_W       = 7;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int LEN_W       = 7;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_GET      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_HEAD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD_TAIL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Value returned when nothing is read
   localparam logic signed [VALUE_W-1:0] NO_VALUE = -32'sd1;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC,
      ST_WALK,
      ST_GET_DATA,
      ST_INS_HEAD,
      ST_INS_LINK,
      ST_INS_PREV,
      ST_DEL_HEAD,
      ST_DEL_NEXT,
      ST_DEL_RELINK,
      ST_DEL_FREE,
      ST_FINISH
   } state_type;

   // Strobes toward the slot memories
   typedef struct packed {
      logic rd_en;
      logic val_we;
      logic lnk_we;
   } mem_ctrl_type;

endpackage

>>> rtl/ills_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Value memory and link memory of the list slots. One shared read address,
// an independent write port on each memory, read data registered.
// ----------------------------------------------------------------------------
module ills_slot_store #(
   parameter int CAPACITY = ills_pkg::DEFAULT_CAPACITY
) (
   input  logic                          clock,
   input  ills_pkg::mem_ctrl_type        ctrl,
   input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
   input  logic [$clog2(CAPACITY)-1:0]   val_wr_addr,
   input  logic [ills_pkg::VALUE_W-1:0]  val_wr_data,
   input  logic [$clog2(CAPACITY)-1:0]   lnk_wr_addr,
   input  logic [$clog2(CAPACITY)-1:0]   lnk_wr_data,
   output logic [ills_pkg::VALUE_W-1:0]  val_rd_data,
   output logic [$clog2(CAPACITY)-1:0]   lnk_rd_data
);

   localparam int SLOT_W = $clog2(CAPACITY);

   logic [ills_pkg::VALUE_W-1:0] value_mem [CAPACITY];
   logic [SLOT_W-1:0]            link_mem  [CAPACITY];
   logic [ills_pkg::VALUE_W-1:0] val_rd_ff;
   logic [SLOT_W-1:0]            lnk_rd_ff;

   // Write the value memory
   always_ff @(posedge clock) begin
      if (ctrl.val_we) begin
         value_mem[val_wr_addr] <= val_wr_data;
      end
   end

   // Write the link memory
   always_ff @(posedge clock) begin
      if (ctrl.lnk_we) begin
         link_mem[lnk_wr_addr] <= lnk_wr_data;
      end
   end

   // Read both memories at the shared address
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         val_rd_ff <= value_mem[rd_addr];
         lnk_rd_ff <= link_mem[rd_addr];
      end
   end

   assign val_rd_data = val_rd_ff;
   assign lnk_rd_data = lnk_rd_ff;

endmodule

>>> rtl/indexed_linked_list_store.sv
// One transaction at a time. Get, insert and delete take longer the further
// their position lies from the head, set by the link walk that follows one
// link per cycle through the link memory port; head adds and head deletes
// skip the walk.
// Reset clears head, length, free chain and fresh slot counter; slot memories
// are not cleared, and a slot's read data is used only after it is written.
// ----------------------------------------------------------------------------
// Indexed linked list store
// Ordered list of signed values kept in linked slots, with get, add at head,
// add at tail, insert before position and delete at position requests.
// ----------------------------------------------------------------------------
module indexed_linked_list_store #(
   parameter int CAPACITY = ills_pkg::DEFAULT_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: req_type[2:0], position[9:3], item_value[41:10], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ills_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: read_value[31:0], status[33:32], list_length[40:34], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ills_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > ills_pkg::POS_W) ? CNT_W : ills_pkg::POS_W;
   localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

   // Controller and list state
   ills_pkg::state_type              state_ff, state_in;
   logic [ills_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [ills_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic signed [ills_pkg::VALUE_W-1:0] item_ff, item_in;
   logic [CNT_W-1:0]                 pidx_ff, pidx_in;
   logic [SLOT_W-1:0]                cur_ff, cur_in;
   logic [CNT_W-1:0]                 steps_ff, steps_in;
   logic                             pending_ff, pending_in;
   logic [SLOT_W-1:0]                slot_ff, slot_in;
   logic [SLOT_W-1:0]                head_ff, head_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [SLOT_W-1:0]                free_ff, free_in;
   logic [CNT_W-1:0]                 fresh_ff, fresh_in;
   logic signed [ills_pkg::VALUE_W-1:0] rd_ff, rd_in;
   logic [ills_pkg::STATUS_W-1:0]    st_ff, st_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ills_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory interface
   ills_pkg::mem_ctrl_type           mem_ctrl;
   logic [SLOT_W-1:0]                rd_addr;
   logic [SLOT_W-1:0]                lnk_wr_addr;
   logic [SLOT_W-1:0]                lnk_wr_data;
   logic [ills_pkg::VALUE_W-1:0]     val_rd_data;
   logic [SLOT_W-1:0]                lnk_rd_data;

   // Decode
   logic                             req_fire;
   logic                             rsp_free;
   logic                             is_get, is_add, is_del;
   logic [CMP_W-1:0]                 pos_ext, count_ext, ins_p;
   logic [CNT_W-1:0]                 pos_cnt;
   logic [ills_pkg::STATUS_W-1:0]    fault_st;
   logic                             refuse;
   logic                             free_avail;
   logic [SLOT_W-1:0]                walk_node;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ills_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pos_ext    = CMP_W'(pos_ff);
   assign pos_cnt    = pos_ext[CNT_W-1:0];
   assign count_ext  = CMP_W'(count_ff);
   assign free_avail = (fresh_ff > count_ff);
   assign walk_node  = pending_ff ? lnk_rd_data : cur_ff;

   // Classify the request and check range and fill
   always_comb begin
      is_get = (kind_ff == ills_pkg::KIND_GET);
      is_add = kind_ff inside {ills_pkg::KIND_ADD_HEAD, ills_pkg::KIND_ADD_TAIL,
                               ills_pkg::KIND_INSERT};
      is_del = (kind_ff == ills_pkg::KIND_DELETE);
      case (kind_ff)
         ills_pkg::KIND_ADD_HEAD: ins_p = '0;
         ills_pkg::KIND_ADD_TAIL: ins_p = count_ext;
         default:                 ins_p = pos_ext;
      endcase
      fault_st = ills_pkg::STATUS_DONE;
      if ((is_get || is_del) && !(pos_ext < count_ext)) begin
         fault_st = ills_pkg::STATUS_RANGE;
      end else if (is_add && (ins_p > count_ext)) begin
         fault_st = ills_pkg::STATUS_RANGE;
      end else if (is_add && (count_ext == CAP_EXT)) begin
         fault_st = ills_pkg::STATUS_FULL;
      end
      refuse = (fault_st != ills_pkg::STATUS_DONE) || !(is_get || is_add || is_del);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ills_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = ills_pkg::ST_DISPATCH;
            end
         end
         ills_pkg::ST_DISPATCH: begin
            if (refuse) begin
               state_in = ills_pkg::ST_FINISH;
            end else if (is_add) begin
               state_in = ills_pkg::ST_ALLOC;
            end else if (is_del && (pos_cnt == '0)) begin
               state_in = ills_pkg::ST_DEL_HEAD;
            end else begin
               state_in = ills_pkg::ST_WALK;
            end
         end
         ills_pkg::ST_ALLOC: begin
            if ((pidx_ff == '0) || (count_ff == '0)) begin
               state_in = ills_pkg::ST_INS_HEAD;
            end else begin
               state_in = ills_pkg::ST_WALK;
            end
         end
         ills_pkg::ST_WALK: begin
            if (steps_ff == '0) begin
               if (is_get) begin
                  state_in = ills_pkg::ST_GET_DATA;
               end else if (is_add) begin
                  state_in = ills_pkg::ST_INS_LINK;
               end else begin
                  state_in = ills_pkg::ST_DEL_NEXT;
               end
            end
         end
         ills_pkg::ST_GET_DATA:   state_in = ills_pkg::ST_FINISH;
         ills_pkg::ST_INS_HEAD:   state_in = ills_pkg::ST_FINISH;
         ills_pkg::ST_INS_LINK:   state_in = ills_pkg::ST_INS_PREV;
         ills_pkg::ST_INS_PREV:   state_in = ills_pkg::ST_FINISH;
         ills_pkg::ST_DEL_HEAD:   state_in = ills_pkg::ST_DEL_FREE;
         ills_pkg::ST_DEL_NEXT:   state_in = ills_pkg::ST_DEL_RELINK;
         ills_pkg::ST_DEL_RELINK: state_in = ills_pkg::ST_DEL_FREE;
         ills_pkg::ST_DEL_FREE:   state_in = ills_pkg::ST_FINISH;
         ills_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = ills_pkg::ST_IDLE;
            end
         end
         default: state_in = ills_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory strobes
   always_comb begin
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      item_in      = item_ff;
      pidx_in      = pidx_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      pending_in   = pending_ff;
      slot_in      = slot_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      free_in      = free_ff;
      fresh_in     = fresh_ff;
      rd_in        = rd_ff;
      st_in        = st_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_ctrl     = '0;
      rd_addr      = cur_ff;
      lnk_wr_addr  = slot_ff;
      lnk_wr_data  = '0;

      case (state_ff)
         // Capture the transaction
         ills_pkg::ST_IDLE: begin
            if (req_fire) begin
               kind_in = req_tdata[2:0];
               pos_in  = req_tdata[9:3];
               item_in = req_tdata[41:10];
            end
         end
         // Set the response defaults; read the free chain or the head link
         ills_pkg::ST_DISPATCH: begin
            rd_in          = ills_pkg::NO_VALUE;
            st_in          = fault_st;
            pidx_in        = is_add ? ins_p[CNT_W-1:0] : pos_cnt;
            cur_in         = head_ff;
            pending_in     = 1'b0;
            steps_in       = is_get ? pos_cnt : pos_cnt - CNT_W'(1);
            mem_ctrl.rd_en = 1'b1;
            rd_addr        = (is_del && (pos_cnt == '0)) ? head_ff : free_ff;
         end
         // Take a recycled slot first, otherwise the next fresh slot
         ills_pkg::ST_ALLOC: begin
            if (free_avail) begin
               slot_in = free_ff;
               free_in = lnk_rd_data;
            end else begin
               slot_in  = fresh_ff[SLOT_W-1:0];
               fresh_in = fresh_ff + CNT_W'(1);
            end
            cur_in     = head_ff;
            pending_in = 1'b0;
            steps_in   = pidx_ff - CNT_W'(1);
         end
         // Follow one link per cycle
         ills_pkg::ST_WALK: begin
            mem_ctrl.rd_en = 1'b1;
            rd_addr        = walk_node;
            cur_in         = walk_node;
            if (steps_ff == '0) begin
               pending_in = 1'b0;
            end else begin
               pending_in = 1'b1;
               steps_in   = steps_ff - CNT_W'(1);
            end
         end
         ills_pkg::ST_GET_DATA: begin
            rd_in = val_rd_data;
         end
         // New entry becomes the head
         ills_pkg::ST_INS_HEAD: begin
            mem_ctrl.val_we = 1'b1;
            mem_ctrl.lnk_we = 1'b1;
            lnk_wr_addr     = slot_ff;
            lnk_wr_data     = (count_ff == '0) ? '0 : head_ff;
            head_in         = slot_ff;
            count_in        = count_ff + CNT_W'(1);
         end
         // New entry takes over the successor of the previous entry
         ills_pkg::ST_INS_LINK: begin
            mem_ctrl.val_we = 1'b1;
            mem_ctrl.lnk_we = 1'b1;
            lnk_wr_addr     = slot_ff;
            lnk_wr_data     = (pidx_ff == count_ff) ? '0 : lnk_rd_data;
         end
         ills_pkg::ST_INS_PREV: begin
            mem_ctrl.lnk_we = 1'b1;
            lnk_wr_addr     = cur_ff;
            lnk_wr_data     = slot_ff;
            count_in        = count_ff + CNT_W'(1);
         end
         // Unhook the head entry
         ills_pkg::ST_DEL_HEAD: begin
            slot_in = head_ff;
            head_in = (count_ff > CNT_W'(1)) ? lnk_rd_data : '0;
         end
         // Fetch the link of the entry to drop
         ills_pkg::ST_DEL_NEXT: begin
            slot_in        = lnk_rd_data;
            mem_ctrl.rd_en = 1'b1;
            rd_addr        = lnk_rd_data;
         end
         ills_pkg::ST_DEL_RELINK: begin
            mem_ctrl.lnk_we = 1'b1;
            lnk_wr_addr     = cur_ff;
            lnk_wr_data     = ((pidx_ff + CNT_W'(1)) == count_ff) ? '0 : lnk_rd_data;
         end
         // Push the dropped slot onto the free chain
         ills_pkg::ST_DEL_FREE: begin
            mem_ctrl.lnk_we = 1'b1;
            lnk_wr_addr     = slot_ff;
            lnk_wr_data     = free_avail ? free_ff : '0;
            free_in         = slot_ff;
            count_in        = count_ff - CNT_W'(1);
         end
         // Hand the result to the output register
         ills_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ills_pkg::RSP_TDATA_W'({count_ext[ills_pkg::LEN_W-1:0],
                                                      st_ff, rd_ff});
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ills_pkg::ST_IDLE;
         pending_ff   <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         free_ff      <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      item_ff     <= item_in;
      pidx_ff     <= pidx_in;
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      slot_ff     <= slot_in;
      rd_ff       <= rd_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

   ills_slot_store #(
      .CAPACITY (CAPACITY)
   ) u_slot_store (
      .clock       (clock),
      .ctrl        (mem_ctrl),
      .rd_addr     (rd_addr),
      .val_wr_addr (slot_ff),
      .val_wr_data (item_ff),
      .lnk_wr_addr (lnk_wr_addr),
      .lnk_wr_data (lnk_wr_data),
      .val_rd_data (val_rd_data),
      .lnk_rd_data (lnk_rd_data)
   );

   // Slot accounting stays consistent
   a_slot_accounting: assert property (@(posedge clock) disable iff (reset)
      (fresh_ff >= count_ff) && (fresh_ff <= CNT_W'(CAPACITY)))
      else $error("fresh slot counter below length or above capacity");

   // Length moves only in the commit states
   a_length_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ills_pkg::ST_INS_HEAD) && (state_ff != ills_pkg::ST_INS_PREV) &&
      (state_ff != ills_pkg::ST_DEL_FREE) |=> (count_ff == $past(count_ff)))
      else $error("list length changed outside a commit state");

   // A walk never runs past the last entry
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ills_pkg::ST_WALK) |-> (steps_ff < count_ff))
      else $error("link walk longer than the list");

   // The output register is loaded only when it is free
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ills_pkg::ST_FINISH) && rsp_valid_ff && !rsp_tready
      |=> (state_ff == ills_pkg::ST_FINISH))
      else $error("result finished while the output register was held");

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Indexed linked list store testbench
// Sends get, add, insert, delete and unknown requests over the request stream.
// A queue-based model of the ordered list predicts each response, which is
// checked field by field. Both stream sides are throttled at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STORE_DEPTH      = ills_pkg::DEFAULT_CAPACITY;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int DRAIN_CYCLES     = 100;

   // Request kinds the block does not decode
   localparam logic [ills_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [ills_pkg::KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
   localparam logic [ills_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

   localparam logic [ills_pkg::POS_W-1:0] POS_MAX = '1;

   localparam logic signed [ills_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [ills_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [ills_pkg::VALUE_W-1:0] read_value;
      logic [ills_pkg::STATUS_W-1:0]       status;
      logic [ills_pkg::LEN_W-1:0]          list_length;
   } list_rsp_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   // req_tdata: req_type[2:0], position[9:3], item_value[41:10], zero pad
   logic [ills_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // rsp_tdata: read_value[31:0], status[33:32], list_length[40:34], zero pad
   logic [ills_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Predicted list contents, head first, and responses still owed by the block
   logic signed [ills_pkg::VALUE_W-1:0] list_values[$];
   list_rsp_type                        expected_responses[$];

   int failures;
   int quiet_cycles;
   bit req_idle_enable;
   bit rsp_idle_enable;
   bit hold_responses_req;
   bit list_growing;

   indexed_linked_list_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Generate the clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request to the list model and return the response it owes
   function automatic list_rsp_type apply_list_request(
         input logic [ills_pkg::KIND_W-1:0] kind,
         input logic [ills_pkg::POS_W-1:0] pos,
         input logic signed [ills_pkg::VALUE_W-1:0] value);
      list_rsp_type rsp;
      int           len;
      int           at;
      rsp.read_value = ills_pkg::NO_VALUE;
      rsp.status     = ills_pkg::STATUS_DONE;
      len            = list_values.size();
      case (kind)
         ills_pkg::KIND_GET: begin
            if (int'(pos) < len) rsp.read_value = list_values[pos];
            else rsp.status = ills_pkg::STATUS_RANGE;
         end
         ills_pkg::KIND_ADD_HEAD, ills_pkg::KIND_ADD_TAIL, ills_pkg::KIND_INSERT: begin
            at = (kind == ills_pkg::KIND_ADD_HEAD) ? 0 :
                 (kind == ills_pkg::KIND_ADD_TAIL) ? len : int'(pos);
            // range test comes before the full test
            if (at > len) rsp.status = ills_pkg::STATUS_RANGE;
            else if (len >= STORE_DEPTH) rsp.status = ills_pkg::STATUS_FULL;
            else if (at == len) list_values.push_back(value);
            else list_values.insert(at, value);
         end
         ills_pkg::KIND_DELETE: begin
            if (int'(pos) < len) list_values.delete(int'(pos));
            else rsp.status = ills_pkg::STATUS_RANGE;
         end
         default: begin
         end
      endcase
      rsp.list_length = ills_pkg::LEN_W'(list_values.size());
      return rsp;
   endfunction

   // Pick a value, leaning on the extremes now and then
   function automatic logic signed [ills_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return ills_pkg::NO_VALUE;
         default: return $urandom;
      endcase
   endfunction

   // Offer one transaction, optionally after an idle burst, and hold until accepted
   task automatic send_request(input logic [ills_pkg::KIND_W-1:0] kind,
                               input logic [ills_pkg::POS_W-1:0] pos,
                               input logic signed [ills_pkg::VALUE_W-1:0] value);
      int gap;
      @(negedge clock);
      if (req_idle_enable && $urandom_range(0, 7) == 0) begin
         gap        = $urandom_range(1, 18);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {6'b0, value, pos, kind};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_responses.push_back(apply_list_request(kind, pos, value));
   endtask

   // Mixed traffic that swings the list between empty and full
   task automatic run_mixed_traffic(input int count);
      int                          len;
      int                          roll;
      logic [ills_pkg::KIND_W-1:0] kind;
      logic [ills_pkg::POS_W-1:0]  pos;
      for (int i = 0; i < count; i++) begin
         len = list_values.size();
         if (len == STORE_DEPTH && $urandom_range(0, 3) == 0) list_growing = 1'b0;
         else if (len == 0) list_growing = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // noise: any kind, any position
            kind = ills_pkg::KIND_W'($urandom_range(0, 7));
            pos  = ills_pkg::POS_W'($urandom_range(0, 127));
         end else if (roll < 20) begin
            kind = ills_pkg::KIND_GET;
            pos  = ills_pkg::POS_W'((len > 0) ? $urandom_range(0, len - 1) : 0);
         end else if (roll < (list_growing ? 80 : 35)) begin
            kind = ills_pkg::KIND_W'($urandom_range(ills_pkg::KIND_ADD_HEAD,
                                                    ills_pkg::KIND_INSERT));
            pos  = ills_pkg::POS_W'((kind == ills_pkg::KIND_INSERT) ?
                                    $urandom_range(0, len) : $urandom_range(0, 127));
         end else begin
            kind = ills_pkg::KIND_DELETE;
            pos  = ills_pkg::POS_W'((len > 0) ? $urandom_range(0, len - 1) : 0);
         end
         send_request(kind, pos, pick_value());
      end
   endtask

   // Empty list: refused reads, deletes, inserts and an unknown kind, then one entry in and out
   task automatic test_empty_store();
      send_request(ills_pkg::KIND_GET, 0, 0);
      send_request(ills_pkg::KIND_DELETE, 0, 0);
      send_request(ills_pkg::KIND_INSERT, 1, 5);
      send_request(KIND_SPARE_FIRST, POS_MAX, ills_pkg::NO_VALUE);
      send_request(ills_pkg::KIND_INSERT, 0, 123);
      send_request(ills_pkg::KIND_GET, 0, 0);
      send_request(ills_pkg::KIND_DELETE, 0, 0);
   endtask

   // Head, tail and middle edits with extreme values, reads of every entry, unknown kinds, deletes
   task automatic test_list_edits();
      send_request(ills_pkg::KIND_ADD_HEAD, POS_MAX, VALUE_MIN);
      send_request(ills_pkg::KIND_ADD_TAIL, POS_MAX, VALUE_MAX);
      send_request(ills_pkg::KIND_ADD_HEAD, 0, 0);
      send_request(ills_pkg::KIND_INSERT, 1, ills_pkg::NO_VALUE);
      // insert at the length appends, one past it is refused
      send_request(ills_pkg::KIND_INSERT, 4, 77);
      send_request(ills_pkg::KIND_INSERT, 6, 88);
      for (int p = 0; p < 5; p++) send_request(ills_pkg::KIND_GET, ills_pkg::POS_W'(p), 0);
      send_request(ills_pkg::KIND_GET, POS_MAX, 0);
      send_request(KIND_SPARE_MID, 2, 9);
      send_request(KIND_SPARE_LAST, 0, VALUE_MAX);
      send_request(ills_pkg::KIND_DELETE, 4, 0);
      send_request(ills_pkg::KIND_DELETE, 1, 0);
      send_request(ills_pkg::KIND_DELETE, 0, 0);
      send_request(ills_pkg::KIND_DELETE, POS_MAX, 0);
   endtask

   // Fill to capacity at random places, hit the full store, then drain it
   task automatic test_full_store();
      logic [ills_pkg::KIND_W-1:0] kind;
      while (list_values.size() < STORE_DEPTH) begin
         kind = ills_pkg::KIND_W'($urandom_range(ills_pkg::KIND_ADD_HEAD,
                                                 ills_pkg::KIND_INSERT));
         send_request(kind, ills_pkg::POS_W'($urandom_range(0, list_values.size())),
                      pick_value());
      end
      send_request(ills_pkg::KIND_ADD_HEAD, 0, 1);
      send_request(ills_pkg::KIND_ADD_TAIL, 0, 2);
      send_request(ills_pkg::KIND_INSERT, ills_pkg::POS_W'(STORE_DEPTH), 3);
      send_request(ills_pkg::KIND_INSERT, ills_pkg::POS_W'(STORE_DEPTH + 1), 4);
      send_request(ills_pkg::KIND_GET, ills_pkg::POS_W'(STORE_DEPTH - 1), 0);
      send_request(ills_pkg::KIND_GET, ills_pkg::POS_W'(STORE_DEPTH), 0);
      while (list_values.size() > 0)
         send_request(ills_pkg::KIND_DELETE,
                      ills_pkg::POS_W'($urandom_range(0, list_values.size() - 1)), 0);
   endtask

   // Random traffic with idle bursts on both sides
   task automatic test_random_traffic();
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
      run_mixed_traffic(600);
   endtask

   // Hold off responses for a long stretch while requests keep coming
   task automatic test_receiver_backpressure();
      hold_responses_req = 1'b1;
      run_mixed_traffic(12);
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_streaming_traffic();
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      run_mixed_traffic(200);
   endtask

   // Drive the response ready with random stalls and the long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_responses_req) begin
            hold_responses_req = 1'b0;
            rsp_tready         = 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else if (rsp_idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Compare each response transaction with the oldest prediction
   always @(posedge clock) begin : check_responses
      list_rsp_type got;
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value  = rsp_tdata[31:0];
         got.status      = rsp_tdata[33:32];
         got.list_length = rsp_tdata[40:34];
         if (expected_responses.size() == 0) begin
            $error("unexpected response transaction, rsp_tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = expected_responses.pop_front();
            if (got.read_value !== want.read_value) begin
               $error("read_value expected %0d actual %0d", want.read_value, got.read_value);
               failures++;
            end
            if (got.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status);
               failures++;
            end
            if (got.list_length !== want.list_length) begin
               $error("list_length expected %0d actual %0d", want.list_length,
                      got.list_length);
               failures++;
            end
         end
      end
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Sequence the tests
   initial begin
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      failures           = 0;
      quiet_cycles       = 0;
      req_idle_enable    = 1'b1;
      rsp_idle_enable    = 1'b1;
      hold_responses_req = 1'b0;
      list_growing       = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_store();
      test_list_edits();
      test_full_store();
      test_random_traffic();
      test_receiver_backpressure();
      test_streaming_traffic();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/ills_pkg.sv
rtl/ills_slot_store.sv
rtl/indexed_linked_list_store.sv
bench/testbench.sv
